### design/ldfw_pkg.sv
`timescale 1ns / 1ps

package ldfw_pkg;

    localparam int MAX_CHARS_DEFAULT = 10;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;
    localparam int CLAMP_W    = 5;

    typedef logic [15:0] value_t;
    typedef logic [3:0]  digit_t;
    typedef logic [7:0]  char_t;

    localparam char_t  CMD_SET_ADDR = 8'h80;
    localparam char_t  CHAR_ZERO    = 8'h30;
    localparam char_t  CHAR_NINE    = 8'h39;
    localparam char_t  CHAR_POINT   = 8'h2E;
    localparam value_t DIV10_MAGIC  = 16'hCCCD;
    localparam int     DIV10_SHIFT  = 19;

endpackage

### design/ldfw_div10.sv
`timescale 1ns / 1ps

module ldfw_div10
(
    input  ldfw_pkg::value_t dividend,
    output ldfw_pkg::value_t quotient,
    output ldfw_pkg::digit_t remainder
);
    import ldfw_pkg::*;

    logic [31:0] product;
    logic [15:0] times_ten;
    logic [15:0] rem_full;

    // reciprocal multiply, exact over the whole 16-bit range
    assign product   = 32'(dividend) * 32'(DIV10_MAGIC);
    assign quotient  = 16'(product[31:DIV10_SHIFT]);
    assign times_ten = {quotient[12:0], 3'b000} + {quotient[14:0], 1'b0};
    assign rem_full  = dividend - times_ten;
    assign remainder = rem_full[3:0];

endmodule

### design/lcd_decimal_field_writer.sv
`timescale 1ns / 1ps

// Writes one decimal field to a character display. Each request yields one
// set-address command (tuser high) and then digit_count (clamped) zero-padded ASCII
// digits, most significant first, with a '.' before the last fraction_digits
// digits; tlast marks the final byte. One divide-by-ten unit produces one
// digit per cycle, then the output register sends one character per cycle
// while the sink does not stall, the point counting as a character. The
// command is offered while the digits are still being extracted. A new
// request is taken only when the previous one has been fully handed to the
// output register.
module lcd_decimal_field_writer
#(
    parameter int MAX_CHARS = ldfw_pkg::MAX_CHARS_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // column[5:0], row[6], value[22:7], digit_count[26:23],
    // fraction_digits[30:27], zero[31]
    input  logic [ldfw_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // byte_out[7:0]
    output logic [ldfw_pkg::OUT_DATA_W-1:0]   m_tdata,
    // is_command[0]
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import ldfw_pkg::*;

    localparam int CW = $clog2(MAX_CHARS + 1);
    localparam int IW = $clog2(MAX_CHARS);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_EXTRACT = 2'd1;
    localparam logic [1:0] ST_EMIT    = 2'd2;

    logic [1:0]   state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] d_reg, d_next;
    logic [CW-1:0] f_reg, f_next;
    logic [CW-1:0] total_reg, total_next;
    value_t       work_value_reg, work_value_next;
    digit_t       digit_store_reg [MAX_CHARS];

    logic         out_valid_reg, out_valid_next;
    logic         out_cmd_reg, out_cmd_next;
    logic         out_last_reg, out_last_next;
    char_t        out_byte_reg, out_byte_next;

    logic         slot_free;
    logic         accept;
    value_t       div_q;
    digit_t       div_r;

    logic [CLAMP_W-1:0] in_d, in_f, f1, d2, f2, fnz_w;
    logic [6:0]   addr;

    logic [CW-1:0] split;
    logic         frac_on;
    logic         is_point;
    logic [CW-1:0] k;
    logic [CW:0]  pos_plus;
    logic         emit_last;
    char_t        emit_char;
    logic [CW-1:0] wr_idx;

    ldfw_div10 u_div10
    (
        .dividend  (work_value_reg),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;

    // clamp the counts
    always_comb
    begin
        in_d  = CLAMP_W'(s_tdata[26:23]);
        in_f  = CLAMP_W'(s_tdata[30:27]);
        f1    = (in_f > in_d) ? in_d : in_f;
        fnz_w = CLAMP_W'(f1 != '0);
        if (in_d + fnz_w > CLAMP_W'(MAX_CHARS))
        begin
            d2 = CLAMP_W'(MAX_CHARS) - fnz_w;
        end
        else
        begin
            d2 = in_d;
        end
        f2   = (f1 > d2) ? d2 : f1;
        addr = {1'b0, s_tdata[5:0]} + {s_tdata[6], 6'b000000};
    end

    always_comb
    begin
        split     = d_reg - f_reg;
        frac_on   = f_reg != '0;
        is_point  = frac_on && (pos_reg == split);
        k         = (frac_on && (pos_reg > split)) ? pos_reg - 1'b1 : pos_reg;
        pos_plus  = {1'b0, pos_reg} + 1'b1;
        emit_last = pos_plus == {1'b0, total_reg};
        emit_char = is_point ? CHAR_POINT
                             : CHAR_ZERO + char_t'(digit_store_reg[k[IW-1:0]]);
        wr_idx    = cnt_reg - 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        d_next          = d_reg;
        f_next          = f_reg;
        total_next      = total_reg;
        work_value_next = work_value_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_cmd_next    = out_cmd_reg;
        out_last_next   = out_last_reg;
        out_byte_next   = out_byte_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    d_next          = d2[CW-1:0];
                    f_next          = f2[CW-1:0];
                    total_next      = CW'(d2 + CLAMP_W'(f2 != '0));
                    cnt_next        = d2[CW-1:0];
                    pos_next        = '0;
                    work_value_next = s_tdata[22:7];
                    out_valid_next  = 1'b1;
                    out_cmd_next    = 1'b1;
                    out_byte_next   = CMD_SET_ADDR | {1'b0, addr};
                    out_last_next   = d2 == '0;
                    state_next      = (d2 == '0) ? ST_IDLE : ST_EXTRACT;
                end
            end
            ST_EXTRACT:
            begin
                work_value_next = div_q;
                cnt_next        = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_cmd_next   = 1'b0;
                    out_byte_next  = emit_char;
                    out_last_next  = emit_last;
                    pos_next       = pos_plus[CW-1:0];
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pos_reg        <= '0;
            d_reg          <= '0;
            f_reg          <= '0;
            total_reg      <= '0;
            work_value_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pos_reg        <= pos_next;
            d_reg          <= d_next;
            f_reg          <= f_next;
            total_reg      <= total_next;
            work_value_reg <= work_value_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cmd_reg  <= out_cmd_next;
        out_last_reg <= out_last_next;
        out_byte_reg <= out_byte_next;
        if (state_reg == ST_EXTRACT)
        begin
            digit_store_reg[wr_idx[IW-1:0]] <= div_r;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_cmd_reg;
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (m_tvalid && m_tuser))
        else $error("request not followed by address command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (state_reg == ST_IDLE))
        else $error("final byte offered while request still in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXTRACT) |-> (cnt_reg != '0))
        else $error("extraction running with no digits left");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg < total_reg))
        else $error("character position beyond field");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_cmd_reg) |->
            (out_byte_reg == CHAR_POINT ||
             (out_byte_reg >= CHAR_ZERO && out_byte_reg <= CHAR_NINE)))
        else $error("character byte is neither digit nor point");

endmodule
